### rtl/fftp_pkg.sv
package fftp_pkg;

   localparam int MaxVlanTags = 2;
   localparam int VlanCountWidth = $clog2(MaxVlanTags + 2);

   typedef enum logic [3:0] {
      PH_ETH   = 4'd0,
      PH_VLAN  = 4'd1,
      PH_PPPOE = 4'd2,
      PH_IP4   = 4'd3,
      PH_IP6   = 4'd4,
      PH_EXT   = 4'd5,
      PH_FRAG  = 4'd6,
      PH_AH    = 4'd7,
      PH_L4    = 4'd8,
      PH_IDLE  = 4'd9
   } phase_type;

   localparam logic [15:0] EtypeVlan   = 16'h8100;
   localparam logic [15:0] EtypeQinq   = 16'h88A8;
   localparam logic [15:0] EtypeIpv4   = 16'h0800;
   localparam logic [15:0] EtypeIpv6   = 16'h86DD;
   localparam logic [15:0] EtypePppoe  = 16'h8864;
   localparam logic [15:0] PppIpv4     = 16'h0021;
   localparam logic [15:0] PppIpv6     = 16'h0057;

   localparam logic [7:0] ProtoIcmp    = 8'd1;
   localparam logic [7:0] ProtoIpip    = 8'd4;
   localparam logic [7:0] ProtoTcp     = 8'd6;
   localparam logic [7:0] ProtoUdp     = 8'd17;
   localparam logic [7:0] ProtoIpv6    = 8'd41;
   localparam logic [7:0] ProtoHop     = 8'd0;
   localparam logic [7:0] ProtoRoute   = 8'd43;
   localparam logic [7:0] ProtoFrag    = 8'd44;
   localparam logic [7:0] ProtoAh      = 8'd51;
   localparam logic [7:0] ProtoIcmp6   = 8'd58;
   localparam logic [7:0] ProtoDest    = 8'd60;
   localparam logic [7:0] ProtoSctp    = 8'd132;
   localparam logic [7:0] ProtoMob     = 8'd135;
   localparam logic [7:0] ProtoHip     = 8'd139;
   localparam logic [7:0] ProtoShim    = 8'd140;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        tuple_valid;
      logic        ip_family;
      logic [7:0]  ip_protocol;
      logic [15:0] low_port;
      logic [15:0] high_port;
      logic [63:0] lower_ip_hi;
      logic [63:0] lower_ip_lo;
      logic [63:0] upper_ip_hi;
      logic [63:0] upper_ip_lo;
   } rsp_type;

endpackage

### rtl/fftp_stream_if.sv
interface fftp_stream_if #(type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/frame_flow_tuple_parser_top.sv
// A request accepted at an edge is parsed from the input register, and the response for
// a last byte is captured in the output register when that register is not stalled.
// Throughput: one byte per cycle; the input stalls only while a last byte waits behind
// a response in the output register that the sink has not taken.
// Reset: synchronous, active high; all parse state returns to the Ethernet phase.
module frame_flow_tuple_parser_top (
   input logic clock,
   input logic reset,
   fftp_stream_if.sink   req,
   fftp_stream_if.source rsp
);
   import fftp_pkg::*;

   // input register
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    stall;
   logic    hold;

   // parse state
   phase_type                 phase_ff, phase_in;
   logic [10:0]               count_ff, count_in;
   logic [10:0]               need_ff, need_in;
   logic [15:0]               etype_ff, etype_in;
   logic [7:0]                nh_ff, nh_in;
   logic [VlanCountWidth-1:0] vlan_ff, vlan_in;
   logic [63:0]               src0_ff, src0_in, src1_ff, src1_in;
   logic [63:0]               dst0_ff, dst0_in, dst1_ff, dst1_in;
   logic [31:0]               pp_ff, pp_in;
   logic [63:0]               t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in;
   logic [7:0]                proto_ff, proto_in;
   logic [15:0]               lport_ff, lport_in, uport_ff, uport_in;
   logic                      fail_ff, fail_in, done_ff, done_in, fam_ff, fam_in;
   logic [4:0]                reach_ff, reach_in;

   rsp_type out_ff, out_in;
   logic    out_valid_ff;

   assign stall = out_valid_ff && !rsp.ready;
   assign hold = in_valid_ff && in_data_ff.last_byte && stall;
   assign req.ready = !hold;
   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;

   // capture request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
      if (req.ready) begin
         in_data_ff <= req.payload;
      end
   end

   // parse one byte
   always_comb begin
      logic [7:0]  b;
      logic [10:0] i;
      logic [10:0] cnt1;
      logic        take;
      logic        hdone;
      logic        s_less;
      logic [31:0] s4, d4;
      logic [7:0]  p;
      logic [15:0] sp, dp;
      logic        v6disp;
      logic        etdisp;
      logic [VlanCountWidth-1:0] vnext;

      b = in_data_ff.data_byte;
      i = count_ff;
      phase_in = phase_ff; count_in = count_ff; need_in = need_ff;
      etype_in = etype_ff; nh_in = nh_ff; vlan_in = vlan_ff;
      src0_in = src0_ff; src1_in = src1_ff; dst0_in = dst0_ff; dst1_in = dst1_ff;
      pp_in = pp_ff; t0_in = t0_ff; t1_in = t1_ff; t2_in = t2_ff; t3_in = t3_ff;
      proto_in = proto_ff; lport_in = lport_ff; uport_in = uport_ff;
      fail_in = fail_ff; done_in = done_ff; fam_in = fam_ff;
      reach_in = (reach_ff != 5'd0) ? reach_ff - 5'd1 : reach_ff;
      take = 1'b1; hdone = 1'b0; v6disp = 1'b0; etdisp = 1'b0;
      s4 = '0; d4 = '0; p = nh_ff; sp = '0; dp = '0; s_less = 1'b0;
      vnext = vlan_ff + 1'b1;

      unique case (phase_ff)
         PH_ETH: begin
            if (i == 11'd12) etype_in = {b, 8'h00};
            if (i == 11'd13) etype_in = {etype_ff[15:8], b};
         end
         PH_VLAN: begin
            if (i == 11'd2) etype_in = {b, 8'h00};
            if (i == 11'd3) etype_in = {etype_ff[15:8], b};
         end
         PH_PPPOE: begin
            if (i == 11'd6) etype_in = {b, 8'h00};
            if (i == 11'd7) etype_in = {etype_ff[15:8], b};
         end
         PH_IP4: begin
            if (i == 11'd9) nh_in = b;
            if (i >= 11'd12 && i < 11'd16) src1_in = {32'h0, src1_ff[23:0], b};
            if (i >= 11'd16 && i < 11'd20) dst1_in = {32'h0, dst1_ff[23:0], b};
         end
         PH_IP6: begin
            if (i == 11'd6) nh_in = b;
            if (i >= 11'd8 && i < 11'd16) src0_in = {src0_ff[55:0], b};
            if (i >= 11'd16 && i < 11'd24) src1_in = {src1_ff[55:0], b};
            if (i >= 11'd24 && i < 11'd32) dst0_in = {dst0_ff[55:0], b};
            if (i >= 11'd32 && i < 11'd40) dst1_in = {dst1_ff[55:0], b};
         end
         PH_EXT: begin
            if (i == 11'd0) nh_in = b;
            if (i == 11'd1) need_in = {b, 3'b000} + 11'd8;
         end
         PH_FRAG: begin
            if (i == 11'd0) nh_in = b;
         end
         PH_AH: begin
            if (i == 11'd0) nh_in = b;
            if (i == 11'd1) begin
               need_in = {1'b0, b, 2'b00} + 11'd8;
               if (reach_in < 5'd18) reach_in = 5'd18;
            end
         end
         PH_L4: begin
            if (i < 11'd4) pp_in = {pp_ff[23:0], b};
            if (i == 11'd3) begin
               sp = pp_in[31:16]; dp = pp_in[15:0];
               lport_in = (sp < dp) ? sp : dp;
               uport_in = (sp < dp) ? dp : sp;
            end
         end
         default: take = 1'b0;
      endcase

      cnt1 = count_ff + 11'd1;
      if (take) begin
         count_in = cnt1;
         hdone = (cnt1 == need_in);
      end

      // dispatch at header end
      if (hdone) begin
         p = nh_in;
         unique case (phase_ff)
            PH_ETH, PH_VLAN: etdisp = 1'b1;
            PH_PPPOE: begin
               if (etype_in == PppIpv4) begin
                  fam_in = 1'b0; phase_in = PH_IP4; count_in = '0; need_in = 11'd20;
               end else if (etype_in == PppIpv6) begin
                  fam_in = 1'b1; phase_in = PH_IP6; count_in = '0; need_in = 11'd40;
               end else begin
                  fail_in = 1'b1; phase_in = PH_IDLE;
               end
            end
            PH_IP4: begin
               s4 = src1_in[31:0]; d4 = dst1_in[31:0];
               t0_in = {(s4 < d4) ? s4 : d4, t0_ff[31:0]};
               t2_in = {(s4 < d4) ? d4 : s4, t2_ff[31:0]};
               proto_in = p;
               count_in = '0;
               if (p == ProtoTcp) begin
                  phase_in = PH_L4; need_in = 11'd20;
               end else if (p == ProtoUdp) begin
                  phase_in = PH_L4; need_in = 11'd8;
               end else if (p == ProtoIcmp) begin
                  lport_in = '0; uport_in = '0; done_in = 1'b1; phase_in = PH_IDLE;
               end else begin
                  fail_in = 1'b1; phase_in = PH_IDLE;
               end
            end
            PH_IP6: begin
               s_less = (src0_in < dst0_in) || (src0_in == dst0_in && src1_in < dst1_in);
               t0_in = s_less ? src0_in : dst0_in;
               t1_in = s_less ? src1_in : dst1_in;
               t2_in = s_less ? dst0_in : src0_in;
               t3_in = s_less ? dst1_in : src1_in;
               v6disp = 1'b1;
            end
            PH_EXT, PH_FRAG, PH_AH: v6disp = 1'b1;
            PH_L4: begin
               done_in = 1'b1; phase_in = PH_IDLE;
            end
            default: ;
         endcase
      end

      // ethertype dispatch
      if (etdisp) begin
         count_in = '0;
         if (etype_in == EtypeVlan || etype_in == EtypeQinq) begin
            vlan_in = vnext;
            if (vnext > VlanCountWidth'(MaxVlanTags)) begin
               fail_in = 1'b1; phase_in = PH_IDLE;
            end else begin
               phase_in = PH_VLAN; need_in = 11'd4;
            end
         end else if (etype_in == EtypeIpv4) begin
            fam_in = 1'b0; phase_in = PH_IP4; need_in = 11'd20;
         end else if (etype_in == EtypeIpv6) begin
            fam_in = 1'b1; phase_in = PH_IP6; need_in = 11'd40;
         end else if (etype_in == EtypePppoe) begin
            phase_in = PH_PPPOE; need_in = 11'd8;
         end else begin
            fail_in = 1'b1; phase_in = PH_IDLE;
         end
      end

      // next-header dispatch
      if (v6disp) begin
         proto_in = p;
         count_in = '0;
         unique case (p)
            ProtoTcp:  begin phase_in = PH_L4; need_in = 11'd20; end
            ProtoUdp:  begin phase_in = PH_L4; need_in = 11'd8; end
            ProtoSctp: begin phase_in = PH_L4; need_in = 11'd12; end
            ProtoIcmp6: begin
               lport_in = '0; uport_in = '0; done_in = 1'b1; phase_in = PH_IDLE;
            end
            ProtoIpip: begin phase_in = PH_IP4; need_in = 11'd20; end
            ProtoIpv6: begin phase_in = PH_IP6; need_in = 11'd40; end
            ProtoHop, ProtoRoute, ProtoDest, ProtoMob, ProtoHip, ProtoShim: begin
               phase_in = PH_EXT; need_in = 11'd2;
            end
            ProtoFrag: begin phase_in = PH_FRAG; need_in = 11'd8; end
            ProtoAh:   begin phase_in = PH_AH; need_in = 11'd2; end
            default:   begin fail_in = 1'b1; phase_in = PH_IDLE; end
         endcase
      end

      // build response
      out_in = '0;
      if (done_in && !fail_in && reach_in == 5'd0) begin
         out_in.tuple_valid = 1'b1;
         out_in.ip_family   = fam_in;
         out_in.ip_protocol = proto_in;
         out_in.low_port    = lport_in;
         out_in.high_port   = uport_in;
         out_in.lower_ip_hi = t0_in;
         out_in.lower_ip_lo = t1_in;
         out_in.upper_ip_hi = t2_in;
         out_in.upper_ip_lo = t3_in;
      end
   end

   // advance parse state
   always_ff @(posedge clock) begin
      if (reset || (in_valid_ff && !hold && in_data_ff.last_byte)) begin
         phase_ff <= PH_ETH; count_ff <= '0; need_ff <= 11'd14;
         etype_ff <= '0; nh_ff <= '0; vlan_ff <= '0;
         src0_ff <= '0; src1_ff <= '0; dst0_ff <= '0; dst1_ff <= '0;
         pp_ff <= '0; t0_ff <= '0; t1_ff <= '0; t2_ff <= '0; t3_ff <= '0;
         proto_ff <= '0; lport_ff <= '0; uport_ff <= '0;
         fail_ff <= 1'b0; done_ff <= 1'b0; fam_ff <= 1'b0; reach_ff <= '0;
      end else if (in_valid_ff && !hold) begin
         phase_ff <= phase_in; count_ff <= count_in; need_ff <= need_in;
         etype_ff <= etype_in; nh_ff <= nh_in; vlan_ff <= vlan_in;
         src0_ff <= src0_in; src1_ff <= src1_in; dst0_ff <= dst0_in; dst1_ff <= dst1_in;
         pp_ff <= pp_in; t0_ff <= t0_in; t1_ff <= t1_in; t2_ff <= t2_in; t3_ff <= t3_in;
         proto_ff <= proto_in; lport_ff <= lport_in; uport_ff <= uport_in;
         fail_ff <= fail_in; done_ff <= done_in; fam_ff <= fam_in; reach_ff <= reach_in;
      end
   end

   // hold response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!stall) begin
         out_valid_ff <= in_valid_ff && in_data_ff.last_byte;
      end
      if (!stall && in_valid_ff && in_data_ff.last_byte) begin
         out_ff <= out_in;
      end
   end

endmodule

### rtl/fftp_checker.sv
module fftp_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         req_last,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic         rsp_tuple_valid,
   input logic [15:0]  rsp_low_port,
   input logic [15:0]  rsp_high_port,
   input logic [7:0]   rsp_ip_protocol
);
   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_low_port))
      else $error("stalled response changed");

   // ports stay ordered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_low_port <= rsp_high_port)
      else $error("ports out of order");

   // invalid response has zero protocol and high port
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tuple_valid |-> rsp_ip_protocol == 8'd0 && rsp_high_port == 16'd0)
      else $error("invalid response not cleared");

   // an accepted last byte yields a response once the output is not stalled
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last ##1 (!rsp_valid || rsp_ready) |=> rsp_valid)
      else $error("response missing");
endmodule

bind frame_flow_tuple_parser_top fftp_checker u_fftp_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready), .req_last(req.payload.last_byte),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_tuple_valid(rsp.payload.tuple_valid),
   .rsp_low_port(rsp.payload.low_port), .rsp_high_port(rsp.payload.high_port),
   .rsp_ip_protocol(rsp.payload.ip_protocol)
);
